// ----- design/tffu_pkg.sv -----
// ----------------------------------------------------------------------------
// tffu_pkg
// Shared constants, command types and fixed-point helpers for the traffic
// flux update sweep.
// ----------------------------------------------------------------------------
package tffu_pkg;

    localparam int QW = 32;
    localparam int FW = 16;
    localparam logic signed [47:0] Q_ONE = 48'sd65536;

    localparam int MODE_W = 2;
    localparam int VM_W   = 31;
    localparam int RM_W   = 31;
    localparam int INV_W  = 31;
    localparam int TXR_W  = 17;

    localparam logic [MODE_W-1:0] MODE_GODUNOV = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LW      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ROE     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_ROE_FIX = 2'd3;

    localparam logic [2:0] REG_FLUX_MODE   = 3'd0;
    localparam logic [2:0] REG_MAX_SPEED   = 3'd1;
    localparam logic [2:0] REG_MAX_DENSITY = 3'd2;
    localparam logic [2:0] REG_INV_DENSITY = 3'd3;
    localparam logic [2:0] REG_STEP_RATIO  = 3'd4;

    localparam logic [VM_W-1:0]  RST_MAX_SPEED   = 31'd65536;
    localparam logic [RM_W-1:0]  RST_MAX_DENSITY = 31'd65536;
    localparam logic [INV_W-1:0] RST_INV_DENSITY = 31'd65536;
    localparam logic [TXR_W-1:0] RST_STEP_RATIO  = 17'd32768;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_IDLE = 5'd0;
    localparam logic [OP_W-1:0] OP_TL   = 5'd1;
    localparam logic [OP_W-1:0] OP_TR   = 5'd2;
    localparam logic [OP_W-1:0] OP_AL   = 5'd3;
    localparam logic [OP_W-1:0] OP_AR   = 5'd4;
    localparam logic [OP_W-1:0] OP_PL   = 5'd5;
    localparam logic [OP_W-1:0] OP_PR   = 5'd6;
    localparam logic [OP_W-1:0] OP_FL   = 5'd7;
    localparam logic [OP_W-1:0] OP_FR   = 5'd8;
    localparam logic [OP_W-1:0] OP_PK   = 5'd9;
    localparam logic [OP_W-1:0] OP_Q    = 5'd10;
    localparam logic [OP_W-1:0] OP_SEL  = 5'd11;
    localparam logic [OP_W-1:0] OP_LT   = 5'd12;
    localparam logic [OP_W-1:0] OP_TE   = 5'd13;
    localparam logic [OP_W-1:0] OP_PE   = 5'd14;
    localparam logic [OP_W-1:0] OP_FE   = 5'd15;
    localparam logic [OP_W-1:0] OP_U1   = 5'd16;
    localparam logic [OP_W-1:0] OP_OUT1 = 5'd17;
    localparam logic [OP_W-1:0] OP_U2   = 5'd18;
    localparam logic [OP_W-1:0] OP_OUT2 = 5'd19;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            mul;
        logic            wb;
        logic            load;
        logic            commit1;
        logic            commit2;
    } t_cmd;

    typedef struct packed {
        logic held;
    } t_status;

    function automatic logic signed [47:0] sx(input logic signed [QW-1:0] v);
        return {{16{v[QW-1]}}, v};
    endfunction

    function automatic logic signed [QW-1:0] sat32(input logic signed [47:0] v);
        logic signed [QW-1:0] r;
        if (v > 48'sh0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -48'sh0000_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [QW-1:0] qrnd(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + 64'sd32768;
        return sat32(t[63:FW]);
    endfunction

endpackage

// ----- design/traffic_flow_flux_update_sweep.sv -----
// ----------------------------------------------------------------------------
// traffic_flow_flux_update_sweep
// Streaming finite-volume flux update of one traffic density row.
// ----------------------------------------------------------------------------
// Cells enter one per beat, left to right, Q16.16. Each cell after the first
// of a row yields the updated previous cell; a last cell also yields itself.
// All products share one multiplier, each product taking a multiply step
// and a writeback step; a new cell is not accepted until the previous one
// has been fully processed and its outputs handed off. Registers are to be
// written over APB only while the block is idle; the block itself does not
// enforce this.
module traffic_flow_flux_update_sweep #(
    parameter logic [tffu_pkg::VM_W-1:0]  P_RST_MAX_SPEED   = tffu_pkg::RST_MAX_SPEED,
    parameter logic [tffu_pkg::RM_W-1:0]  P_RST_MAX_DENSITY = tffu_pkg::RST_MAX_DENSITY,
    parameter logic [tffu_pkg::INV_W-1:0] P_RST_INV_DENSITY = tffu_pkg::RST_INV_DENSITY,
    parameter logic [tffu_pkg::TXR_W-1:0] P_RST_STEP_RATIO  = tffu_pkg::RST_STEP_RATIO
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // density
    input  logic        i_s_axis_tuser,   // first_cell
    input  logic        i_s_axis_tlast,   // last_cell
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // new_density
    output logic        o_m_axis_tlast,   // row_end
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [tffu_pkg::MODE_W-1:0] r_mode;
    logic [tffu_pkg::VM_W-1:0]   r_vm;
    logic [tffu_pkg::RM_W-1:0]   r_rhom;
    logic [tffu_pkg::INV_W-1:0]  r_inv;
    logic [tffu_pkg::TXR_W-1:0]  r_txr;
    logic [2:0]                  reg_idx;
    tffu_pkg::t_cmd              cmd;
    tffu_pkg::t_status           status;
    logic signed [31:0]          new_density;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tffu_pkg::MODE_GODUNOV;
            r_vm   <= P_RST_MAX_SPEED;
            r_rhom <= P_RST_MAX_DENSITY;
            r_inv  <= P_RST_INV_DENSITY;
            r_txr  <= P_RST_STEP_RATIO;
        end else if (psel && penable && pwrite && pready) begin
            unique case (reg_idx)
                tffu_pkg::REG_FLUX_MODE:   r_mode <= pwdata[tffu_pkg::MODE_W-1:0];
                tffu_pkg::REG_MAX_SPEED:   r_vm   <= pwdata[tffu_pkg::VM_W-1:0];
                tffu_pkg::REG_MAX_DENSITY: r_rhom <= pwdata[tffu_pkg::RM_W-1:0];
                tffu_pkg::REG_INV_DENSITY: r_inv  <= pwdata[tffu_pkg::INV_W-1:0];
                tffu_pkg::REG_STEP_RATIO:  r_txr  <= pwdata[tffu_pkg::TXR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            tffu_pkg::REG_FLUX_MODE:   prdata = {30'd0, r_mode};
            tffu_pkg::REG_MAX_SPEED:   prdata = {1'b0, r_vm};
            tffu_pkg::REG_MAX_DENSITY: prdata = {1'b0, r_rhom};
            tffu_pkg::REG_INV_DENSITY: prdata = {1'b0, r_inv};
            tffu_pkg::REG_STEP_RATIO:  prdata = {15'd0, r_txr};
            default:                   prdata = '0;
        endcase
    end

    tffu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_first     (i_s_axis_tuser),
        .i_last      (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .i_mode      (r_mode),
        .i_status    (status),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    tffu_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_density     (i_s_axis_tdata),
        .i_first       (i_s_axis_tuser),
        .i_last        (i_s_axis_tlast),
        .i_mode        (r_mode),
        .i_vm          (r_vm),
        .i_rhom        (r_rhom),
        .i_inv         (r_inv),
        .i_txr         (r_txr),
        .o_status      (status),
        .o_new_density (new_density),
        .o_row_end     (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = new_density;

endmodule

// ----- design/tffu_ctrl.sv -----
// ----------------------------------------------------------------------------
// tffu_ctrl
// Sequencer: walks the multiply schedule for one cell and runs the
// input and output handshakes.
// ----------------------------------------------------------------------------
module tffu_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_first,
    input  logic                           i_last,
    input  logic                           i_out_ready,
    input  logic [tffu_pkg::MODE_W-1:0]    i_mode,
    input  tffu_pkg::t_status              i_status,
    output logic                           o_in_ready,
    output logic                           o_out_valid,
    output tffu_pkg::t_cmd                 o_cmd
);

    logic [tffu_pkg::OP_W-1:0] r_state, n_state;
    logic r_phase, n_phase;
    logic r_iface, n_iface;
    logic r_last, n_last;
    logic is_mul, lw, step_done, in_acc, out_acc, iface_in;
    logic [tffu_pkg::OP_W-1:0] nxt;

    assign lw = (i_mode == tffu_pkg::MODE_LW);
    assign is_mul = !(r_state == tffu_pkg::OP_IDLE || r_state == tffu_pkg::OP_SEL ||
                      r_state == tffu_pkg::OP_OUT1 || r_state == tffu_pkg::OP_OUT2);
    assign o_in_ready  = (r_state == tffu_pkg::OP_IDLE);
    assign o_out_valid = (r_state == tffu_pkg::OP_OUT1) || (r_state == tffu_pkg::OP_OUT2);
    assign in_acc  = o_in_ready && i_in_valid;
    assign out_acc = o_out_valid && i_out_ready;
    assign iface_in = i_status.held && !i_first;
    assign step_done = is_mul ? r_phase : (r_state == tffu_pkg::OP_SEL);

    always_comb begin
        unique case (r_state)
            tffu_pkg::OP_TL:  nxt = tffu_pkg::OP_TR;
            tffu_pkg::OP_TR:  nxt = !r_iface ? tffu_pkg::OP_PR
                                   : (lw ? tffu_pkg::OP_PL : tffu_pkg::OP_AL);
            tffu_pkg::OP_AL:  nxt = tffu_pkg::OP_AR;
            tffu_pkg::OP_AR:  nxt = tffu_pkg::OP_PL;
            tffu_pkg::OP_PL:  nxt = tffu_pkg::OP_PR;
            tffu_pkg::OP_PR:  nxt = r_iface ? tffu_pkg::OP_FL : tffu_pkg::OP_FR;
            tffu_pkg::OP_FL:  nxt = tffu_pkg::OP_FR;
            tffu_pkg::OP_FR:  nxt = !r_iface ? tffu_pkg::OP_U2
                                   : (lw ? tffu_pkg::OP_LT : tffu_pkg::OP_PK);
            tffu_pkg::OP_PK:  nxt = tffu_pkg::OP_Q;
            tffu_pkg::OP_Q:   nxt = tffu_pkg::OP_SEL;
            tffu_pkg::OP_SEL: nxt = tffu_pkg::OP_U1;
            tffu_pkg::OP_LT:  nxt = tffu_pkg::OP_TE;
            tffu_pkg::OP_TE:  nxt = tffu_pkg::OP_PE;
            tffu_pkg::OP_PE:  nxt = tffu_pkg::OP_FE;
            tffu_pkg::OP_FE:  nxt = tffu_pkg::OP_U1;
            tffu_pkg::OP_U1:  nxt = tffu_pkg::OP_OUT1;
            tffu_pkg::OP_U2:  nxt = tffu_pkg::OP_OUT2;
            default:          nxt = tffu_pkg::OP_IDLE;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_iface = r_iface;
        n_last  = r_last;
        priority if (r_state == tffu_pkg::OP_IDLE) begin
            if (i_in_valid) begin
                n_iface = iface_in;
                n_last  = i_last;
                n_phase = 1'b0;
                n_state = iface_in ? tffu_pkg::OP_TL
                        : (i_last ? tffu_pkg::OP_TR : tffu_pkg::OP_IDLE);
            end
        end else if (r_state == tffu_pkg::OP_OUT1) begin
            if (i_out_ready) begin
                n_state = r_last ? tffu_pkg::OP_U2 : tffu_pkg::OP_IDLE;
            end
        end else if (r_state == tffu_pkg::OP_OUT2) begin
            if (i_out_ready) begin
                n_state = tffu_pkg::OP_IDLE;
            end
        end else if (step_done) begin
            n_state = nxt;
            n_phase = 1'b0;
        end else begin
            n_phase = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tffu_pkg::OP_IDLE;
            r_phase <= 1'b0;
            r_iface <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_iface <= n_iface;
            r_last  <= n_last;
        end
    end

    always_comb begin
        o_cmd.op      = r_state;
        o_cmd.mul     = is_mul && !r_phase;
        o_cmd.wb      = (is_mul && r_phase) || (r_state == tffu_pkg::OP_SEL);
        o_cmd.load    = in_acc;
        o_cmd.commit1 = out_acc && (r_state == tffu_pkg::OP_OUT1);
        o_cmd.commit2 = out_acc && (r_state == tffu_pkg::OP_OUT2);
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("input and output open together");
    a_wb_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wb && is_mul) |-> $past(o_cmd.mul)) else $error("writeback without product");
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (iface_in || i_last)) |=> (r_state != tffu_pkg::OP_IDLE))
        else $error("work item dropped");

endmodule

// ----- design/tffu_dp.sv -----
// ----------------------------------------------------------------------------
// tffu_dp
// Datapath: cell and flux registers, one shared Q16.16 multiplier with a
// product register, rounding writeback and scheme selection.
// ----------------------------------------------------------------------------
module tffu_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tffu_pkg::t_cmd                    i_cmd,
    input  logic signed [tffu_pkg::QW-1:0]    i_density,
    input  logic                              i_first,
    input  logic                              i_last,
    input  logic [tffu_pkg::MODE_W-1:0]       i_mode,
    input  logic [tffu_pkg::VM_W-1:0]         i_vm,
    input  logic [tffu_pkg::RM_W-1:0]         i_rhom,
    input  logic [tffu_pkg::INV_W-1:0]        i_inv,
    input  logic [tffu_pkg::TXR_W-1:0]        i_txr,
    output tffu_pkg::t_status                 o_status,
    output logic signed [tffu_pkg::QW-1:0]    o_new_density,
    output logic                              o_row_end
);

    logic signed [31:0] r_l, r_r, r_fl, r_tl, r_tr, r_al, r_ar, r_pl, r_pr;
    logic signed [31:0] r_fvl, r_fvr, r_pk, r_q, r_e, r_te, r_pe, r_fr, r_out;
    logic               r_held, r_last, r_row_end;
    logic signed [63:0] r_prod;
    logic signed [31:0] op_a, op_b, rq, vm, rhom, inv, txr, sel;
    logic signed [47:0] fix_sum;

    assign vm   = {1'b0, i_vm};
    assign rhom = {1'b0, i_rhom};
    assign inv  = {1'b0, i_inv};
    assign txr  = {{(32-tffu_pkg::TXR_W){1'b0}}, i_txr};
    assign rq   = tffu_pkg::qrnd(r_prod);

    always_comb begin
        op_a = r_l;
        op_b = inv;
        unique case (i_cmd.op)
            tffu_pkg::OP_TL: begin op_a = r_l; op_b = inv; end
            tffu_pkg::OP_TR: begin op_a = r_r; op_b = inv; end
            tffu_pkg::OP_AL: begin
                op_a = vm;
                op_b = tffu_pkg::sat32(tffu_pkg::Q_ONE - (tffu_pkg::sx(r_tl) <<< 1));
            end
            tffu_pkg::OP_AR: begin
                op_a = vm;
                op_b = tffu_pkg::sat32(tffu_pkg::Q_ONE - (tffu_pkg::sx(r_tr) <<< 1));
            end
            tffu_pkg::OP_PL: begin op_a = r_l; op_b = vm; end
            tffu_pkg::OP_PR: begin op_a = r_r; op_b = vm; end
            tffu_pkg::OP_FL: begin
                op_a = r_pl;
                op_b = tffu_pkg::sat32(tffu_pkg::Q_ONE - tffu_pkg::sx(r_tl));
            end
            tffu_pkg::OP_FR: begin
                op_a = r_pr;
                op_b = tffu_pkg::sat32(tffu_pkg::Q_ONE - tffu_pkg::sx(r_tr));
            end
            tffu_pkg::OP_PK: begin op_a = rhom; op_b = vm; end
            tffu_pkg::OP_Q: begin
                op_a = tffu_pkg::sat32(tffu_pkg::sx(r_ar) - tffu_pkg::sx(r_al));
                op_b = tffu_pkg::sat32(tffu_pkg::sx(r_r) - tffu_pkg::sx(r_l));
            end
            tffu_pkg::OP_LT: begin
                op_a = txr;
                op_b = tffu_pkg::sat32(tffu_pkg::sx(r_fvr) - tffu_pkg::sx(r_fvl));
            end
            tffu_pkg::OP_TE: begin op_a = r_e; op_b = inv; end
            tffu_pkg::OP_PE: begin op_a = r_e; op_b = vm; end
            tffu_pkg::OP_FE: begin
                op_a = r_pe;
                op_b = tffu_pkg::sat32(tffu_pkg::Q_ONE - tffu_pkg::sx(r_te));
            end
            tffu_pkg::OP_U1: begin
                op_a = txr;
                op_b = tffu_pkg::sat32(tffu_pkg::sx(r_fr) - tffu_pkg::sx(r_fl));
            end
            tffu_pkg::OP_U2: begin
                op_a = txr;
                op_b = tffu_pkg::sat32(tffu_pkg::sx(r_fvr) - tffu_pkg::sx(r_fl));
            end
            default: begin op_a = r_l; op_b = inv; end
        endcase
    end

    // scheme choice once both wave speeds and fluxes are in
    always_comb begin
        fix_sum = (tffu_pkg::sx(r_fvl) <<< 1) + (tffu_pkg::sx(r_fvr) <<< 1) - tffu_pkg::sx(r_q);
        sel = ((tffu_pkg::sx(r_al) + tffu_pkg::sx(r_ar)) >= 48'sd0) ? r_fvl : r_fvr;
        if (r_al <= 32'sd0 && r_ar >= 32'sd0) begin
            if (i_mode == tffu_pkg::MODE_GODUNOV) begin
                sel = r_pk >>> 2;
            end else if (i_mode == tffu_pkg::MODE_ROE_FIX) begin
                sel = tffu_pkg::sat32(fix_sum >>> 2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= 64'(op_a) * 64'(op_b);
        end
        if (i_cmd.wb) begin
            unique case (i_cmd.op)
                tffu_pkg::OP_TL:  r_tl  <= rq;
                tffu_pkg::OP_TR:  r_tr  <= rq;
                tffu_pkg::OP_AL:  r_al  <= rq;
                tffu_pkg::OP_AR:  r_ar  <= rq;
                tffu_pkg::OP_PL:  r_pl  <= rq;
                tffu_pkg::OP_PR:  r_pr  <= rq;
                tffu_pkg::OP_FL:  r_fvl <= rq;
                tffu_pkg::OP_FR:  r_fvr <= rq;
                tffu_pkg::OP_PK:  r_pk  <= rq;
                tffu_pkg::OP_Q:   r_q   <= rq;
                tffu_pkg::OP_SEL: r_fr  <= sel;
                tffu_pkg::OP_LT:
                    r_e <= tffu_pkg::sat32((tffu_pkg::sx(r_l) + tffu_pkg::sx(r_r)
                                            - tffu_pkg::sx(rq)) >>> 1);
                tffu_pkg::OP_TE:  r_te  <= rq;
                tffu_pkg::OP_PE:  r_pe  <= rq;
                tffu_pkg::OP_FE:  r_fr  <= rq;
                tffu_pkg::OP_U1: begin
                    r_out     <= tffu_pkg::sat32(tffu_pkg::sx(r_l) - tffu_pkg::sx(rq));
                    r_row_end <= 1'b0;
                end
                tffu_pkg::OP_U2: begin
                    r_out     <= tffu_pkg::sat32(tffu_pkg::sx(r_r) - tffu_pkg::sx(rq));
                    r_row_end <= 1'b1;
                end
                default: ;
            endcase
        end
        if (i_cmd.load) begin
            r_r    <= i_density;
            r_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l    <= '0;
            r_fl   <= '0;
            r_held <= 1'b0;
        end else if (i_cmd.load) begin
            if (i_first || !r_held) begin
                r_fl   <= '0;
                r_held <= 1'b0;
                if (!i_last) begin
                    r_l    <= i_density;
                    r_held <= 1'b1;
                end
            end
        end else if (i_cmd.commit1) begin
            r_fl <= r_fr;
            if (!r_last) begin
                r_l <= r_r;
            end
        end else if (i_cmd.commit2) begin
            r_l    <= '0;
            r_fl   <= '0;
            r_held <= 1'b0;
        end
    end

    assign o_status.held = r_held;
    assign o_new_density = r_out;
    assign o_row_end     = r_row_end;

endmodule

// ----- tb/sv/traffic_flow_flux_update_sweep_tb.sv -----
// ----------------------------------------------------------------------------
// traffic_flow_flux_update_sweep_tb
// Streams density rows through the flux update block under every flux scheme
// and several register settings, predicts each updated cell in Q16.16 and
// compares it beat by beat, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module traffic_flow_flux_update_sweep_tb;

    typedef struct packed {
        logic [31:0] density;
        logic        first_cell;
        logic        last_cell;
    } t_cell;

    typedef struct packed {
        logic [31:0] new_density;
        logic        row_end;
    } t_upd;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;
    logic        i_s_axis_tuser;
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    traffic_flow_flux_update_sweep u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata), .i_s_axis_tuser(i_s_axis_tuser),
        .i_s_axis_tlast(i_s_axis_tlast),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata), .o_m_axis_tlast(o_m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [1:0] cfg_mode;
    longint     cfg_vm, cfg_rm, cfg_inv, cfg_txr;
    longint     st_held, st_lflux;
    bit         st_valid;

    t_cell   cell_q[$];
    t_upd    upd_q[$];
    int      in_idle_pct, out_stall_pct;
    int      errors;
    longint  cycles;
    bit      in_taken;

    function automatic longint sat_q(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fdiv(longint q, longint d);
        longint r;
        r = q % d;
        if (r < 0) r += d;
        return (q - r) / d;
    endfunction

    function automatic longint qm(longint x, longint y);
        return sat_q(fdiv(x * y + 32768, 65536));
    endfunction

    function automatic longint speed_of(longint r);
        return qm(cfg_vm, sat_q(65536 - 2 * qm(r, cfg_inv)));
    endfunction

    function automatic longint flux_of(longint r);
        return qm(qm(r, cfg_vm), sat_q(65536 - qm(r, cfg_inv)));
    endfunction

    function automatic longint iface_flux(longint l, longint r);
        longint al, ar, fl, fr, t, e, p;
        if (cfg_mode == tffu_pkg::MODE_LW) begin
            t = qm(cfg_txr, sat_q(flux_of(r) - flux_of(l)));
            e = sat_q(fdiv(l + r - t, 2));
            return flux_of(e);
        end
        al = speed_of(l);
        ar = speed_of(r);
        fl = flux_of(l);
        fr = flux_of(r);
        if (cfg_mode == tffu_pkg::MODE_GODUNOV && al <= 0 && ar >= 0)
            return fdiv(qm(cfg_rm, cfg_vm), 4);
        if (cfg_mode == tffu_pkg::MODE_ROE_FIX && al <= 0 && ar >= 0) begin
            p = qm(sat_q(ar - al), sat_q(r - l));
            return sat_q(fdiv(2 * fl + 2 * fr - p, 4));
        end
        return (al + ar >= 0) ? fl : fr;
    endfunction

    function automatic longint cell_update(longint c, longint fl, longint fr);
        return sat_q(c - qm(cfg_txr, sat_q(fr - fl)));
    endfunction

    task automatic predict_cell(t_cell c);
        longint d, fr;
        t_upd   u;
        d = longint'($signed(c.density));
        if (c.first_cell || !st_valid) begin
            st_valid = 0;
            st_lflux = 0;
        end else begin
            fr = iface_flux(st_held, d);
            u.new_density = 32'(cell_update(st_held, st_lflux, fr));
            u.row_end = 0;
            upd_q.push_back(u);
            st_lflux = fr;
        end
        if (c.last_cell) begin
            u.new_density = 32'(cell_update(d, st_lflux, flux_of(d)));
            u.row_end = 1;
            upd_q.push_back(u);
            st_valid = 0;
            st_held = 0;
            st_lflux = 0;
        end else begin
            st_held = d;
            st_valid = 1;
        end
    endtask

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 64'd3000000) begin
            $display("traffic_flow_flux_update_sweep_tb failed");
            $finish;
        end
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_axis_tvalid || in_taken) begin
                if (cell_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
                    i_s_axis_tdata  <= cell_q[0].density;
                    i_s_axis_tuser  <= cell_q[0].first_cell;
                    i_s_axis_tlast  <= cell_q[0].last_cell;
                    i_s_axis_tvalid <= 1'b1;
                    void'(cell_q.pop_front());
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_upd u;
        in_taken <= 0;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_cell({i_s_axis_tdata, i_s_axis_tuser, i_s_axis_tlast});
                in_taken <= 1;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (upd_q.size() == 0) begin
                    $error("unexpected beat new_density %h", o_m_axis_tdata);
                    errors++;
                end else begin
                    u = upd_q.pop_front();
                    if (o_m_axis_tdata !== u.new_density) begin
                        $error("new_density expected %h actual %h", u.new_density,
                               o_m_axis_tdata);
                        errors++;
                    end
                    if (o_m_axis_tlast !== u.row_end) begin
                        $error("row_end expected %b actual %b", u.row_end, o_m_axis_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1;
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            tffu_pkg::REG_FLUX_MODE:   cfg_mode = val[1:0];
            tffu_pkg::REG_MAX_SPEED:   cfg_vm   = longint'(val[30:0]);
            tffu_pkg::REG_MAX_DENSITY: cfg_rm   = longint'(val[30:0]);
            tffu_pkg::REG_INV_DENSITY: cfg_inv  = longint'(val[30:0]);
            tffu_pkg::REG_STEP_RATIO:  cfg_txr  = longint'(val[16:0]);
            default: ;
        endcase
    endtask

    task automatic drain();
        while (cell_q.size() > 0 || i_s_axis_tvalid || upd_q.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic push_cell(logic [31:0] d, logic f, logic l);
        t_cell c;
        c.density = d; c.first_cell = f; c.last_cell = l;
        cell_q.push_back(c);
    endtask

    function automatic logic [31:0] rand_density();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'h8000_0000 | $urandom_range(3);
            2: return 32'h7FFF_FFFC | $urandom_range(3);
            default: return $urandom_range(32'h0002_0000);
        endcase
    endfunction

    task automatic random_rows(int n);
        int k, len, j;
        k = 0;
        while (k < n) begin
            if ($urandom_range(9) == 0) begin
                push_cell(rand_density(), 1'($urandom_range(1)), 1'($urandom_range(1)));
                k++;
            end else begin
                len = $urandom_range(1, 8);
                for (j = 0; j < len; j++)
                    push_cell(rand_density(), j == 0, j == len - 1);
                k += len;
            end
        end
    endtask

    task automatic random_config();
        apb_write(tffu_pkg::REG_FLUX_MODE, $urandom_range(3));
        apb_write(tffu_pkg::REG_MAX_SPEED,
                  $urandom_range(1, 4) * 32'h4000 + $urandom_range(255));
        apb_write(tffu_pkg::REG_MAX_DENSITY,
                  $urandom_range(1, 4) * 32'h8000 + $urandom_range(255));
        apb_write(tffu_pkg::REG_INV_DENSITY,
                  $urandom_range(1, 4) * 32'h4000 + $urandom_range(255));
        apb_write(tffu_pkg::REG_STEP_RATIO, $urandom_range(65536));
    endtask

    initial begin
        int ph, m;
        i_rst_n = 0;
        i_s_axis_tvalid = 0; i_s_axis_tdata = 0; i_s_axis_tuser = 0; i_s_axis_tlast = 0;
        i_m_axis_tready = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_idle_pct = 0; out_stall_pct = 0; errors = 0; cycles = 0;
        in_taken = 0;
        cfg_mode = tffu_pkg::MODE_GODUNOV; cfg_vm = 65536; cfg_rm = 65536; cfg_inv = 65536;
        cfg_txr = 32768;
        st_held = 0; st_lflux = 0; st_valid = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed rows at reset settings, then each scheme
        for (m = 0; m < 4; m++) begin
            if (m > 0) apb_write(tffu_pkg::REG_FLUX_MODE, m);
            push_cell(32'h0000_4000, 1, 0);
            push_cell(32'h0000_C000, 0, 0);
            push_cell(32'h7FFF_FFFF, 0, 0);
            push_cell(32'h8000_0000, 0, 1);
            push_cell(32'h0001_0000, 1, 1);          // lone cell
            push_cell(32'h0000_8000, 0, 0);          // row with no first flag
            push_cell(32'h0000_2000, 1, 0);          // restart drops held cell
            push_cell(32'hFFFF_0000, 0, 1);
            drain();
        end
        // register extremes
        apb_write(tffu_pkg::REG_MAX_SPEED, 32'hFFFF_FFFF);
        apb_write(tffu_pkg::REG_MAX_DENSITY, 32'h7FFF_FFFF);
        apb_write(tffu_pkg::REG_INV_DENSITY, 32'h0000_0000);
        apb_write(tffu_pkg::REG_STEP_RATIO, 32'h0001_0000);
        push_cell($urandom(), 1, 0); push_cell($urandom(), 0, 1);
        drain();
        apb_write(tffu_pkg::REG_MAX_SPEED, 0);
        apb_write(tffu_pkg::REG_MAX_DENSITY, 1);
        apb_write(tffu_pkg::REG_INV_DENSITY, 32'h7FFF_FFFF);
        apb_write(tffu_pkg::REG_STEP_RATIO, 0);
        push_cell($urandom(), 1, 0); push_cell($urandom(), 0, 1);
        drain();

        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 75; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 75; end
                default: begin in_idle_pct = 6; out_stall_pct = 6; end
            endcase
            random_config();
            random_rows(80);
            drain();
        end

        if (errors == 0 && upd_q.size() == 0) begin
            $display("traffic_flow_flux_update_sweep_tb passed");
        end else begin
            $display("traffic_flow_flux_update_sweep_tb failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/tffu_pkg.sv
design/tffu_ctrl.sv
design/tffu_dp.sv
design/traffic_flow_flux_update_sweep.sv
tb/sv/traffic_flow_flux_update_sweep_tb.sv
